// ----- hw/rtl/multiset_table_assert.svh -----
// ----------------------------------------------------------------------------
// multiset_table_assert.svh
// Assertion macros for the multiset table. They are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTISET_TABLE_ASSERT_SVH
`define MULTISET_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge out of reset.
`define MST_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("multiset_table: assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define MST_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("multiset_table: assertion failed");

`else

`define MST_ASSERT_ALWAYS(label, clk, rst, cond)
`define MST_ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/mst_pkg.sv -----
// ----------------------------------------------------------------------------
// mst_pkg
// Types and constants shared by the multiset table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mst_pkg;

  localparam int DISTINCT_CAPACITY_DEF = 64;
  localparam int TOTAL_CAPACITY_DEF    = 1024;
  localparam int KEY_WIDTH_DEF         = 32;

  // Fixed field widths of the request and response
  localparam int KEY_FIELD_W   = 32;
  localparam int COUNT_FIELD_W = 11;
  localparam int DIST_FIELD_W  = 7;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [KEY_FIELD_W-1:0] key;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic                     was_present;
    logic [COUNT_FIELD_W-1:0] key_count;
    logic [COUNT_FIELD_W-1:0] total_size;
    logic [DIST_FIELD_W-1:0]  distinct_size;
    logic                     is_empty;
  } rsp_t;

endpackage

// ----- hw/rtl/mst_store.sv -----
// ----------------------------------------------------------------------------
// mst_store
// Entry memory: key and count per slot, one write port, one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mst_store #(
  parameter int DEPTH = mst_pkg::DISTINCT_CAPACITY_DEF,
  parameter int KW    = mst_pkg::KEY_WIDTH_DEF,
  parameter int CW    = $clog2(mst_pkg::TOTAL_CAPACITY_DEF + 1)
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [KW-1:0]            rd_key,
  output logic [CW-1:0]            rd_cnt,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [KW-1:0]            wr_key,
  input  logic [CW-1:0]            wr_cnt
);

  logic [KW-1:0] key_mem [DEPTH];
  logic [CW-1:0] cnt_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      cnt_mem[wr_addr] <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_cnt <= cnt_mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/multiset_table.sv -----
// ----------------------------------------------------------------------------
// multiset_table
// Bag of keys with a count per distinct key, kept in insertion order.
// ----------------------------------------------------------------------------
// Each request (add, remove or query of one key) is handled alone by a small
// sequencer around one entry memory with a single read and a single write
// port. A linear scan reads one stored key per cycle and stops at the first
// match. With n distinct keys stored, an add, a query or a remove that keeps
// the key scans at most those n keys, then updates the entry and registers
// its response. A remove that drops a key's count to zero also compacts the
// later entries, one entry per cycle, before it responds. A response that is
// held by rsp_stall delays the end of the request by the length of the stall.
// The request side is stalled while a request is in progress. A finished
// response waits in an output register, and the next request may be accepted
// meanwhile, from the same cycle in which the response appears.
`timescale 1ns / 1ps

`include "multiset_table_assert.svh"

module multiset_table #(
  parameter int DISTINCT_CAPACITY = mst_pkg::DISTINCT_CAPACITY_DEF,
  parameter int TOTAL_CAPACITY    = mst_pkg::TOTAL_CAPACITY_DEF,
  parameter int KEY_WIDTH         = mst_pkg::KEY_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  mst_pkg::req_t req,
  output logic          req_stall,
  output logic          rsp_valid,
  output mst_pkg::rsp_t rsp,
  input  logic          rsp_stall
);

  import mst_pkg::*;

  localparam int KW = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
  localparam int AW = $clog2(DISTINCT_CAPACITY);
  localparam int DW = $clog2(DISTINCT_CAPACITY + 1);
  localparam int CW = $clog2(TOTAL_CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t        state;
  opcode_t       op;
  logic [KW-1:0] key_q;
  logic [DW-1:0] idx;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic [AW-1:0] pos;
  logic          found;
  logic [CW-1:0] cnt;
  status_t       status;
  logic [DW-1:0] distinct;
  logic [CW-1:0] total;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [KW-1:0] rd_key;
  logic [CW-1:0] rd_cnt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [KW-1:0] wr_key;
  logic [CW-1:0] wr_cnt;

  logic          hit;
  logic          tot_full;
  logic          dist_full;
  logic          add_found;
  logic          add_new;
  logic          rem_keep;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] cnt_dec;
  logic [31:0]   cnt_w;
  logic [31:0]   tot_w;
  logic [31:0]   dist_w;

  mst_store #(
    .DEPTH (DISTINCT_CAPACITY),
    .KW    (KW),
    .CW    (CW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_cnt  (rd_cnt),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_cnt  (wr_cnt)
  );

  assign hit       = pend && (rd_key == key_q);
  assign tot_full  = total >= CW'(TOTAL_CAPACITY);
  assign dist_full = distinct >= DW'(DISTINCT_CAPACITY);
  assign cnt_inc   = cnt + CW'(1);
  assign cnt_dec   = (cnt != '0) ? cnt - CW'(1) : '0;
  assign add_found = (op == OP_ADD) && !tot_full && found;
  assign add_new   = (op == OP_ADD) && !tot_full && !found && !dist_full;
  assign rem_keep  = (op == OP_REMOVE) && found && (cnt_dec != '0);

  assign req_stall = (state != S_IDLE);

  assign cnt_w  = 32'(cnt);
  assign tot_w  = 32'(total);
  assign dist_w = 32'(distinct);

  // Memory port steering
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_key  = key_q;
    wr_cnt  = cnt_dec;
    case (state)
      S_SCAN: begin
        rd_en = !hit && (idx != distinct);
      end
      S_EXEC: begin
        wr_en = add_found || add_new || rem_keep;
        if (add_new) begin
          wr_addr = distinct[AW-1:0];
          wr_cnt  = CW'(1);
        end else if (add_found) begin
          wr_cnt = cnt_inc;
        end
      end
      S_SHIFT: begin
        // read slot idx while writing the previously read slot one place down
        rd_en   = (idx != distinct);
        wr_en   = pend;
        wr_addr = pend_addr - AW'(1);
        wr_key  = rd_key;
        wr_cnt  = rd_cnt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      distinct  <= '0;
      total     <= '0;
      pend      <= 1'b0;
    end else begin
      // S_DONE drives rsp_valid itself
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op    <= opcode_t'(req.opcode);
            key_q <= req.key[KW-1:0];
            idx   <= '0;
            pend  <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            found <= 1'b1;
            pos   <= pend_addr;
            cnt   <= rd_cnt;
            pend  <= 1'b0;
            state <= S_EXEC;
          end else if (idx == distinct) begin
            found <= 1'b0;
            cnt   <= '0;
            pend  <= 1'b0;
            state <= S_EXEC;
          end else begin
            pend      <= 1'b1;
            pend_addr <= idx[AW-1:0];
            idx       <= idx + DW'(1);
          end
        end
        S_EXEC: begin
          status <= STAT_OK;
          state  <= S_DONE;
          case (op)
            OP_ADD: begin
              if (tot_full) begin
                status <= STAT_FULL;
              end else if (found) begin
                cnt   <= cnt_inc;
                total <= total + CW'(1);
              end else if (dist_full) begin
                status <= STAT_FULL;
              end else begin
                cnt      <= CW'(1);
                distinct <= distinct + DW'(1);
                total    <= total + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (!found) begin
                status <= STAT_NOT_FOUND;
              end else begin
                cnt <= cnt_dec;
                if (total != '0) begin
                  total <= total - CW'(1);
                end
                if (cnt_dec == '0) begin
                  idx   <= DW'(pos) + DW'(1);
                  pend  <= 1'b0;
                  state <= S_SHIFT;
                end
              end
            end
            default: begin
            end
          endcase
        end
        S_SHIFT: begin
          if (idx != distinct) begin
            pend      <= 1'b1;
            pend_addr <= idx[AW-1:0];
            idx       <= idx + DW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              distinct <= distinct - DW'(1);
              state    <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid         <= 1'b1;
            rsp.status        <= status;
            rsp.was_present   <= found;
            rsp.key_count     <= cnt_w[COUNT_FIELD_W-1:0];
            rsp.total_size    <= tot_w[COUNT_FIELD_W-1:0];
            rsp.distinct_size <= dist_w[DIST_FIELD_W-1:0];
            rsp.is_empty      <= (distinct == '0);
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the dropped key still counts as distinct until compaction ends
  `MST_ASSERT_ALWAYS(a_total_cap, clk, rst, total <= CW'(TOTAL_CAPACITY))
  `MST_ASSERT_IMPLY(a_total_ge_distinct, clk, rst, state != S_SHIFT, 32'(total) >= 32'(distinct))
  `MST_ASSERT_IMPLY(a_rsp_from_done, clk, rst, $rose(rsp_valid), $past(state == S_DONE))

endmodule

// ----- bench/multiset_table_tb.sv -----
// ----------------------------------------------------------------------------
// multiset_table_tb
// Self-checking bench for the multiset table. Requests go in at the falling
// edge and responses are taken at the rising edge. Both sides idle and stall
// at random. Each accepted request is applied to a private copy of the bag,
// which gives the response to expect. Responses are compared field by field,
// in order. The stimulus fills the table to both capacity limits, then churns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multiset_table_tb;
  import mst_pkg::*;

  localparam int         N_DISTINCT = DISTINCT_CAPACITY_DEF;
  localparam int         N_TOTAL    = TOTAL_CAPACITY_DEF;
  localparam logic [1:0] OP_SPARE   = 2'd3;  // unused code, handled as a query
  localparam int         IDLE_PCT   = 37;
  localparam int         POOL_SIZE  = 24;
  localparam int         MAX_PRINTS = 200;

  class bag_checker;
    logic [KEY_FIELD_W-1:0] keys[N_DISTINCT];
    int unsigned            counts[N_DISTINCT];
    int unsigned            n_distinct;
    int unsigned            n_total;
    rsp_t                   pending_rsp[$];
    int unsigned            n_errors;

    function int locate(logic [KEY_FIELD_W-1:0] k);
      for (int i = 0; i < n_distinct; i++)
        if (keys[i] == k) return i;
      return -1;
    endfunction

    // Apply one accepted request to the bag and queue the response it yields.
    function void note_request(req_t r);
      rsp_t        want;
      int          pos;
      int unsigned cnt;
      pos = locate(r.key);
      cnt = (pos >= 0) ? counts[pos] : 0;
      want.status      = STAT_OK;
      want.was_present = (pos >= 0);
      case (r.opcode)
        OP_ADD: begin
          if (n_total >= N_TOTAL) begin
            want.status = STAT_FULL;
          end else if (pos >= 0) begin
            cnt++;
            counts[pos] = cnt;
            n_total++;
          end else if (n_distinct >= N_DISTINCT) begin
            want.status = STAT_FULL;
          end else begin
            keys[n_distinct]   = r.key;
            counts[n_distinct] = 1;
            n_distinct++;
            n_total++;
            cnt = 1;
          end
        end
        OP_REMOVE: begin
          if (pos < 0) begin
            want.status = STAT_NOT_FOUND;
          end else begin
            cnt--;
            n_total--;
            if (cnt == 0) begin
              // later entries move down one slot, order kept
              for (int i = pos; i + 1 < n_distinct; i++) begin
                keys[i]   = keys[i + 1];
                counts[i] = counts[i + 1];
              end
              n_distinct--;
            end else begin
              counts[pos] = cnt;
            end
          end
        end
        default: ;
      endcase
      want.key_count     = COUNT_FIELD_W'(cnt);
      want.total_size    = COUNT_FIELD_W'(n_total);
      want.distinct_size = DIST_FIELD_W'(n_distinct);
      want.is_empty      = (n_distinct == 0);
      pending_rsp.push_back(want);
    endfunction

    task report(string msg);
      // cap the log when the block is badly off, keep counting
      if (n_errors < MAX_PRINTS) $display("MISMATCH: %s", msg);
      n_errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        report($sformatf("response %0h with no request outstanding", got));
        return;
      end
      want = pending_rsp.pop_front();
      compare_field("status", 32'(got.status), 32'(want.status));
      compare_field("was_present", 32'(got.was_present), 32'(want.was_present));
      compare_field("key_count", 32'(got.key_count), 32'(want.key_count));
      compare_field("total_size", 32'(got.total_size), 32'(want.total_size));
      compare_field("distinct_size", 32'(got.distinct_size), 32'(want.distinct_size));
      compare_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
    endtask
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  logic rsp_valid;
  logic rsp_stall;
  req_t req;
  rsp_t rsp;

  bit                     steady;  // no idling on either side while set
  bag_checker             bag_model;
  logic [KEY_FIELD_W-1:0] key_pool[POOL_SIZE];

  multiset_table DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_stall (rsp_stall)
  );

  always #1 clk = ~clk;

  function automatic bit roll_idle();
    return !steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic logic [KEY_FIELD_W-1:0] pool_key();
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic logic [KEY_FIELD_W-1:0] stored_key();
    if (bag_model.n_distinct == 0) return pool_key();
    return bag_model.keys[$urandom_range(bag_model.n_distinct - 1)];
  endfunction

  // Entered at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(logic [1:0] op, logic [KEY_FIELD_W-1:0] k);
    req_t r;
    r.opcode = op;
    r.key    = k;
    if (roll_idle()) begin
      req_valid <= 1'b0;
      req.key   <= $urandom();  // garbage while idle
      do @(negedge clk); while (roll_idle());
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    bag_model.note_request(r);
    @(negedge clk);
  endtask

  task automatic churn(int n_items, int add_pct, bit from_store);
    int                     roll;
    logic [KEY_FIELD_W-1:0] k;
    repeat (n_items) begin
      roll = $urandom_range(99);
      k    = (from_store && $urandom_range(3) != 0) ? stored_key() : pool_key();
      if (roll < add_pct)  send_request(OP_ADD, k);
      else if (roll < 88)  send_request(OP_REMOVE, k);
      else if (roll < 95)  send_request(OP_QUERY, k);
      else                 send_request(OP_SPARE, k);
    end
  endtask

  always @(negedge clk) rsp_stall <= roll_idle();

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) bag_model.check_response(rsp);
  end

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    steady    = 1'b0;
    bag_model = new;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table, unknown keys, spare opcode
    send_request(OP_QUERY, '0);
    send_request(OP_REMOVE, 32'h0000_0005);
    send_request(OP_SPARE, '1);
    // build a few entries at the key extremes
    send_request(OP_ADD, '0);
    send_request(OP_ADD, '1);
    send_request(OP_ADD, '1);
    send_request(OP_ADD, 32'h5555_5555);
    send_request(OP_ADD, 32'hAAAA_AAAA);
    send_request(OP_QUERY, '1);
    send_request(OP_SPARE, '0);
    send_request(OP_REMOVE, '1);
    // drop the first entry, then a middle one, then the last
    send_request(OP_REMOVE, '0);
    send_request(OP_REMOVE, '0);
    send_request(OP_REMOVE, 32'h5555_5555);
    send_request(OP_REMOVE, 32'hAAAA_AAAA);
    send_request(OP_REMOVE, '1);
    send_request(OP_QUERY, '1);
    send_request(OP_ADD, 32'hAAAA_AAAA);

    churn(200, 50, 1'b0);

    // all distinct slots taken, back to back
    steady = 1'b1;
    while (bag_model.n_distinct < N_DISTINCT) begin
      if ($urandom_range(7) == 0) send_request(OP_QUERY, stored_key());
      else                        send_request(OP_ADD, $urandom());
    end
    repeat (6) send_request(OP_ADD, $urandom());
    repeat (6) send_request(OP_ADD, stored_key());
    steady = 1'b0;

    // total occurrences up to capacity
    while (bag_model.n_total < N_TOTAL) begin
      case ($urandom_range(31))
        0:       send_request(OP_REMOVE, stored_key());
        1:       send_request(OP_ADD, $urandom());
        default: send_request(OP_ADD, stored_key());
      endcase
    end
    repeat (4) send_request(OP_ADD, stored_key());
    repeat (4) send_request(OP_ADD, $urandom());
    send_request(OP_QUERY, stored_key());

    churn(120, 15, 1'b1);

    req_valid <= 1'b0;
    while (bag_model.pending_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (bag_model.n_errors == 0) begin
      $display("multiset_table_tb: done, clean");
    end else begin
      $display("multiset_table_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("multiset_table_tb: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/mst_pkg.sv
hw/rtl/mst_store.sv
hw/rtl/multiset_table.sv
bench/multiset_table_tb.sv
